[rtl/core/quadtree_point_histogram_macros.svh]
// assertion macros for the quadtree point histogram
// expects clk and rst_n in the scope of each use
`ifndef QUADTREE_POINT_HISTOGRAM_MACROS_SVH
`define QUADTREE_POINT_HISTOGRAM_MACROS_SVH

// same-cycle implication, checked out of reset
`define QPH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define QPH_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/qph_pkg.sv]
// shared types, constants and helpers of the quadtree point histogram
// no dependencies
`default_nettype none

package qph_pkg;

  // tree shape and counter width
  localparam int unsigned LEVELS     = 6;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned NCELLS     = ((1 << (2 * LEVELS)) - 1) / 3;
  localparam int unsigned IDX_W      = $clog2(NCELLS);
  localparam int unsigned LVL_W      = $clog2(LEVELS);

  // fixed field widths of the channels
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned COORD_W    = 32;
  localparam int unsigned CELL_IN_W  = 11;
  localparam int unsigned LEVEL_IN_W = 3;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned SUM_W      = 42;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned LEAF_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // request queue depth
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // command codes
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATS = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_X_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH = 2'd3;

  // work classes decided by the front end
  typedef enum logic [1:0] {
    OP_ADD,
    OP_READ,
    OP_STATS,
    OP_ZERO
  } opclass_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_ADD_WB,
    ST_RD,
    ST_STATS,
    ST_DRAIN,
    ST_DONE
  } bstate_t;

  // one classified request
  typedef struct packed {
    logic [CMD_W-1:0]   kind;
    opclass_t           opc;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [IDX_W-1:0]   addr;   // read cell, or first cell of a level
    logic [IDX_W-1:0]   last;   // last cell of a level
  } op_t;

  // area bounds
  typedef struct packed {
    logic [COORD_W-1:0] x_low;
    logic [COORD_W-1:0] x_high;
    logic [COORD_W-1:0] y_low;
    logic [COORD_W-1:0] y_high;
  } bounds_t;

  // one result
  typedef struct packed {
    logic [CMD_W-1:0]   kind;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   level_sum;
    logic [SQ_W-1:0]    level_sum_squares;
    logic [LEAF_W-1:0]  leaf_cell;
  } result_t;

  // back end status seen by the front end
  typedef struct packed {
    logic clearing;
  } bstatus_t;

  // first breadth-first cell of a level: 1 + 4 + ... + 4^(l-1)
  function automatic logic [IDX_W-1:0] level_first(input logic [LEVEL_IN_W-1:0] l);
    logic [IDX_W-1:0] base;
    base = '0;
    for (int unsigned k = 0; k < LEVELS - 1; k++) begin
      if (k < 32'(l)) begin
        base = (base << 2) | IDX_W'(1);
      end
    end
    return base;
  endfunction

endpackage

`default_nettype wire

[rtl/core/qph_if.sv]
// channel interfaces of the quadtree point histogram: request, result, register write
// depends on qph_pkg
`default_nettype none

interface qph_in_if import qph_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [COORD_W-1:0]    x;
  logic [COORD_W-1:0]    y;
  logic [CELL_IN_W-1:0]  cell_index;
  logic [LEVEL_IN_W-1:0] level;

  modport source (output valid, cmd, x, y, cell_index, level, input ready);
  modport sink   (input valid, cmd, x, y, cell_index, level, output ready);
endinterface

interface qph_out_if import qph_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   kind;
  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   level_sum;
  logic [SQ_W-1:0]    level_sum_squares;
  logic [LEAF_W-1:0]  leaf_cell;

  modport source (output valid, kind, count, level_sum, level_sum_squares, leaf_cell,
                  input ready);
  modport sink   (input valid, kind, count, level_sum, level_sum_squares, leaf_cell,
                  output ready);
endinterface

interface qph_cfg_if import qph_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/core/quadtree_point_histogram.sv]
// top level of the quadtree point histogram: front end, request queue, back end
// depends on qph_pkg, qph_if, qph_front, qph_fifo and qph_back
//
// channels: in_ch takes requests (cmd, x, y, cell_index, level), out_ch gives one
// result per request (kind, count, level_sum, level_sum_squares, leaf_cell) in
// request order, cfg_ch writes the area bounds x_low, x_high, y_low, y_high by
// index 0..3; register writes are always taken and belong between requests
// requests pass a classifying front end into a two-entry queue, so the input keeps
// taking requests while the back end works or a result waits in the output register
// the back end does one request at a time against a single-port-read counter memory:
//   add        one counter read-modify-write per level
//   read       one counter read
//   statistics the 4^level counters of the level, one counter per cycle through a square-and-add pipe
//   others     a zero result, no counter access
// reset (synchronous, active low) restores the bounds to the full range and starts a
// clearing pass over all 1365 counters, one counter per cycle, with in_ch.ready held low
// a stalled receiver holds the result register; the back end then waits in its done
// state and the queue fills, after which in_ch.ready drops
`default_nettype none

module quadtree_point_histogram import qph_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qph_in_if.sink    in_ch,
  qph_out_if.source out_ch,
  qph_cfg_if.sink   cfg_ch
);

  // queue handshake
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_empty;
  op_t      q_in_op;
  op_t      q_out_op;

  // area bounds and back end status
  bounds_t  bounds;
  bstatus_t status;

  qph_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .status (status),
    .q_push (q_push),
    .q_op   (q_in_op),
    .bounds (bounds)
  );

  qph_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in_op),
    .pop     (q_pop),
    .pop_op  (q_out_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  qph_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_op    (q_out_op),
    .q_pop   (q_pop),
    .bounds  (bounds),
    .status  (status),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[rtl/core/qph_fifo.sv]
// two-entry queue of classified requests between front and back end
// depends on qph_pkg
`default_nettype none

module qph_fifo import qph_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output op_t  pop_op,
  output logic full,
  output logic empty
);

  op_t               ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic [QPTR_W:0]   cnt_nxt;

  assign full   = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign empty  = (cnt_r == '0);
  assign pop_op = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QPTR_W+1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QPTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

`default_nettype wire

[rtl/core/qph_front.sv]
// front end: area registers, request intake and classification into queue entries
// depends on qph_pkg and qph_if
`default_nettype none

module qph_front import qph_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qph_in_if.sink    in_ch,
  qph_cfg_if.sink   cfg_ch,
  input  logic      q_full,
  input  bstatus_t  status,
  output logic      q_push,
  output op_t       q_op,
  output bounds_t   bounds
);

  bounds_t bounds_r;

  assign bounds       = bounds_r;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_full && !status.clearing;
  assign q_push       = in_ch.valid && in_ch.ready;

  // range checks turn bad reads and levels, and unknown commands, into zero answers
  always_comb begin
    q_op      = '0;
    q_op.kind = in_ch.cmd;
    q_op.x    = in_ch.x;
    q_op.y    = in_ch.y;
    q_op.opc  = OP_ZERO;
    case (in_ch.cmd)
      CMD_ADD: begin
        q_op.opc = OP_ADD;
      end
      CMD_READ: begin
        q_op.addr = IDX_W'(in_ch.cell_index);
        if (32'(in_ch.cell_index) < NCELLS) begin
          q_op.opc = OP_READ;
        end
      end
      CMD_STATS: begin
        q_op.addr = level_first(in_ch.level);
        q_op.last = level_first(in_ch.level) << 2;
        if (32'(in_ch.level) < LEVELS) begin
          q_op.opc = OP_STATS;
        end
      end
      default: begin
        q_op.opc = OP_ZERO;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r.x_low  <= '0;
      bounds_r.x_high <= '1;
      bounds_r.y_low  <= '0;
      bounds_r.y_high <= '1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_X_LOW:  bounds_r.x_low  <= COORD_W'(cfg_ch.data);
        CFG_X_HIGH: bounds_r.x_high <= COORD_W'(cfg_ch.data);
        CFG_Y_LOW:  bounds_r.y_low  <= COORD_W'(cfg_ch.data);
        CFG_Y_HIGH: bounds_r.y_high <= COORD_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/qph_back.sv]
// back end: cell counter memory, add/read/statistics sequencer and result register
// depends on qph_pkg, qph_if and the assertion macro header
`default_nettype none
`include "quadtree_point_histogram_macros.svh"

module qph_back import qph_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  op_t       q_op,
  output logic      q_pop,
  input  bounds_t   bounds,
  output bstatus_t  status,
  qph_out_if.source out_ch
);

  localparam logic [LVL_W-1:0] LVL_LAST = LVL_W'(LEVELS - 1);
  localparam logic [IDX_W-1:0] CELL_LAST = IDX_W'(NCELLS - 1);

  bstate_t state_r, state_nxt;

  // counter memory
  logic [COUNT_BITS-1:0] cell_mem_r [NCELLS];
  logic [COUNT_BITS-1:0] rdata_r;
  logic                  mem_ren;
  logic [IDX_W-1:0]      mem_raddr;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;

  // control
  op_t              op_r;
  logic [IDX_W-1:0] addr_r;
  logic [LVL_W-1:0] lvl_r;
  logic             wb_pend_r;
  logic [IDX_W-1:0] wb_addr_r;
  logic             p1_r, p2_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             res_load;
  result_t          res_r, res_nxt;

  // bisection
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [COORD_W-1:0] xl_r, xh_r, yl_r, yh_r;
  logic [COORD_W-1:0] mid_x, mid_y;
  logic               x_hi, y_hi;

  // statistics
  logic [2*COUNT_BITS-1:0] prod_w;
  logic [SQ_W-1:0]         prod_r;
  logic [COUNT_BITS-1:0]   c_r;
  logic [SUM_W-1:0]        sum_r;
  logic [SQ_W-1:0]         sq_r;
  logic [SUM_W:0]          sum_add;
  logic [SQ_W:0]           sq_add;

  assign status.clearing = (state_r == ST_CLEAR);
  assign out_free        = !out_valid_r || out_ch.ready;

  // quadrant choice for the current level
  always_comb begin
    mid_x   = COORD_W'(({1'b0, xl_r} + {1'b0, xh_r}) >> 1);
    mid_y   = COORD_W'(({1'b0, yl_r} + {1'b0, yh_r}) >> 1);
    x_hi    = (op_r.x > mid_x);
    y_hi    = (op_r.y > mid_y);
    idx_nxt = (idx_r << 2) + IDX_W'({y_hi, x_hi}) + IDX_W'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (addr_r == CELL_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          case (q_op.opc)
            OP_ADD:   state_nxt = ST_ADD;
            OP_READ:  state_nxt = ST_RD;
            OP_STATS: state_nxt = ST_STATS;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_ADD: begin
        if (lvl_r == LVL_LAST) begin
          state_nxt = ST_ADD_WB;
        end
      end
      ST_ADD_WB: state_nxt = ST_DONE;
      ST_RD:     state_nxt = ST_DONE;
      ST_STATS: begin
        if (addr_r == op_r.last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!p1_r && !p2_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    mem_ren   = 1'b0;
    mem_raddr = addr_r;
    res_load  = 1'b0;
    case (state_r)
      ST_IDLE: q_pop = !q_empty;
      ST_ADD: begin
        mem_ren   = 1'b1;
        mem_raddr = idx_r;
      end
      ST_RD: begin
        mem_ren   = 1'b1;
        mem_raddr = op_r.addr;
      end
      ST_STATS: begin
        mem_ren   = 1'b1;
        mem_raddr = addr_r;
      end
      ST_DONE: res_load = out_free;
      default: ;
    endcase
  end

  // write port: clearing pass, else saturating increment of the previous add read
  always_comb begin
    mem_we    = status.clearing || wb_pend_r;
    mem_waddr = status.clearing ? addr_r : wb_addr_r;
    mem_wdata = '0;
    if (!status.clearing) begin
      mem_wdata = (rdata_r == '1) ? rdata_r : rdata_r + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_ren) begin
      rdata_r <= cell_mem_r[mem_raddr];
    end
  end

  // statistics pipeline arithmetic
  always_comb begin
    prod_w  = (2*COUNT_BITS)'(rdata_r) * (2*COUNT_BITS)'(rdata_r);
    sum_add = {1'b0, sum_r} + (SUM_W+1)'(c_r);
    sq_add  = {1'b0, sq_r} + {1'b0, prod_r};
  end

  // result assembly
  always_comb begin
    res_nxt      = '0;
    res_nxt.kind = op_r.kind;
    case (op_r.opc)
      OP_ADD:   res_nxt.leaf_cell = LEAF_W'(idx_r);
      OP_READ:  res_nxt.count     = COUNT_W'(rdata_r);
      OP_STATS: begin
        res_nxt.level_sum         = sum_r;
        res_nxt.level_sum_squares = sq_r;
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = res_load || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      lvl_r       <= '0;
      wb_pend_r   <= 1'b0;
      p1_r        <= 1'b0;
      p2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_pend_r   <= (state_r == ST_ADD);
      p1_r        <= (state_r == ST_STATS);
      p2_r        <= p1_r;
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_CLEAR: addr_r <= addr_r + IDX_W'(1);
        ST_STATS: addr_r <= addr_r + IDX_W'(1);
        ST_IDLE: begin
          if (q_pop) begin
            addr_r <= q_op.addr;
            lvl_r  <= '0;
          end
        end
        ST_ADD: lvl_r <= lvl_r + LVL_W'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    wb_addr_r <= idx_r;
    if (q_pop) begin
      op_r  <= q_op;
      idx_r <= '0;
      xl_r  <= bounds.x_low;
      xh_r  <= bounds.x_high;
      yl_r  <= bounds.y_low;
      yh_r  <= bounds.y_high;
      sum_r <= '0;
      sq_r  <= '0;
    end
    if (state_r == ST_ADD && lvl_r != LVL_LAST) begin
      idx_r <= idx_nxt;
      xl_r  <= x_hi ? mid_x : xl_r;
      xh_r  <= x_hi ? xh_r : mid_x;
      yl_r  <= y_hi ? mid_y : yl_r;
      yh_r  <= y_hi ? yh_r : mid_y;
    end
    if (p1_r) begin
      c_r    <= rdata_r;
      prod_r <= SQ_W'(prod_w);
    end
    if (p2_r) begin
      sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      sq_r  <= sq_add[SQ_W] ? '1 : sq_add[SQ_W-1:0];
    end
    if (res_load) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.kind              = res_r.kind;
  assign out_ch.count             = res_r.count;
  assign out_ch.level_sum         = res_r.level_sum;
  assign out_ch.level_sum_squares = res_r.level_sum_squares;
  assign out_ch.leaf_cell         = res_r.leaf_cell;

  `QPH_ASSERT_IMP(a_wb_only_in_add, wb_pend_r,
                  (state_r == ST_ADD) || (state_r == ST_ADD_WB),
                  "counter write-back outside an add")
  `QPH_ASSERT_IMP(a_rmw_no_alias, wb_pend_r && mem_ren, wb_addr_r != mem_raddr,
                  "add reads the cell it is writing back")
  `QPH_ASSERT_IMP(a_stats_in_level, state_r == ST_STATS, addr_r <= op_r.last,
                  "statistics walk ran past the level")
  `QPH_ASSERT_NXT(a_add_last_wb, (state_r == ST_ADD) && (lvl_r == LVL_LAST),
                  wb_pend_r && (state_r == ST_ADD_WB),
                  "deepest cell of an add not written back")

endmodule

`default_nettype wire
